FILE: rtl/core/ldr_pkg.sv
`default_nettype none
package ldr_pkg;

  localparam int NORM_FRAC = 16;
  localparam int NORM_MAX  = 131071;
  localparam int NORM_MIN  = -131072;
  localparam int Q_W       = 18;
  localparam int DIV_STEPS = 18;
  localparam int COLOR_W   = 24;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIAL_2     = 3'd2;
  localparam logic [2:0] REG_RADIAL_4     = 3'd3;
  localparam logic [2:0] REG_TANGENTIAL_1 = 3'd4;
  localparam logic [2:0] REG_TANGENTIAL_2 = 3'd5;

  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
  } out_item_t;

  typedef struct packed {
    logic [11:0] mag;
    logic        neg;
  } div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           neg;
    logic           sat;
  } div_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/ldr_stream_if.sv
`default_nettype none
interface ldr_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lens_distortion_pixel_remap.sv
// Each pixel passes a one-bit-per-stage divider that normalizes x and y by width
//   and height on its way to the registered result.
// Throughput: one pixel per cycle; each stage moves on when the next one frees,
//   so bubbles close up under output stall. Off-frame pixels leave no result.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`default_nettype none
module lens_distortion_pixel_remap #(
  parameter int MAX_SIDE       = 4096,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  ldr_stream_if.sink   pixel,
  ldr_stream_if.source result
);

  localparam int DS   = ldr_pkg::DIV_STEPS;
  localparam int P0   = DS + 1;
  localparam int LAST = DS + 12;
  localparam int NST  = LAST + 1;
  localparam int CF   = COEF_FRAC_BITS;

  logic [12:0]        frame_width;
  logic [12:0]        frame_height;
  logic signed [15:0] radial_coef_2;
  logic signed [15:0] radial_coef_4;
  logic signed [15:0] tangential_coef_1;
  logic signed [15:0] tangential_coef_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= ldr_pkg::WIDTH_RESET;
      frame_height      <= ldr_pkg::HEIGHT_RESET;
      radial_coef_2     <= '0;
      radial_coef_4     <= '0;
      tangential_coef_1 <= '0;
      tangential_coef_2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ldr_pkg::REG_FRAME_WIDTH:  frame_width       <= cfg_data[12:0];
        ldr_pkg::REG_FRAME_HEIGHT: frame_height      <= cfg_data[12:0];
        ldr_pkg::REG_RADIAL_2:     radial_coef_2     <= signed'(cfg_data);
        ldr_pkg::REG_RADIAL_4:     radial_coef_4     <= signed'(cfg_data);
        ldr_pkg::REG_TANGENTIAL_1: tangential_coef_1 <= signed'(cfg_data);
        ldr_pkg::REG_TANGENTIAL_2: tangential_coef_2 <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  logic [12:0] w_side;
  logic [12:0] h_side;
  logic [11:0] half_w;
  logic [11:0] half_h;

  assign w_side = (32'(frame_width) > MAX_SIDE) ? 13'(MAX_SIDE) : frame_width;
  assign h_side = (32'(frame_height) > MAX_SIDE) ? 13'(MAX_SIDE) : frame_height;
  assign half_w = w_side[12:1];
  assign half_h = h_side[12:1];

  // ---------------------------------------------------------------- flow control
  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  logic           in_frame;

  always_comb begin
    adv[LAST] = !v[LAST] || result.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign pixel.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= pixel.valid && (w_side != '0) && (h_side != '0);
      end
      for (int k = 1; k < LAST; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
      // drop pixels that land off the frame
      if (adv[LAST]) begin
        v[LAST] <= v[LAST-1] && in_frame;
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic signed [12:0] diff_x;
  logic signed [12:0] diff_y;
  ldr_pkg::div_in_t   lane_x;
  ldr_pkg::div_in_t   lane_y;
  logic [ldr_pkg::COLOR_W-1:0] col0;

  assign diff_x = signed'({1'b0, pixel.data.src_x}) - signed'({1'b0, half_w});
  assign diff_y = signed'({1'b0, pixel.data.src_y}) - signed'({1'b0, half_h});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lane_x.neg <= diff_x[12];
      lane_x.mag <= diff_x[12] ? 12'(-diff_x) : 12'(diff_x);
      lane_y.neg <= diff_y[12];
      lane_y.mag <= diff_y[12] ? 12'(-diff_y) : 12'(diff_y);
      col0       <= {pixel.data.in_red, pixel.data.in_green, pixel.data.in_blue};
    end
  end

  // ---------------------------------------------------------------- divider
  ldr_pkg::div_out_t           qx;
  ldr_pkg::div_out_t           qy;
  logic [ldr_pkg::COLOR_W-1:0] col_div;

  ldr_norm_div #(.SIDE_W(ldr_pkg::COLOR_W)) u_div (
    .clk      (clk),
    .adv      (adv[DS:1]),
    .div_x    (w_side),
    .div_y    (h_side),
    .in_x     (lane_x),
    .in_y     (lane_y),
    .side_in  (col0),
    .out_x    (qx),
    .out_y    (qy),
    .side_out (col_div)
  );

  function automatic logic signed [17:0] clamp_norm(input ldr_pkg::div_out_t d);
    logic signed [17:0] r;
    if (!d.neg) begin
      r = (d.sat || d.q > 18'(ldr_pkg::NORM_MAX)) ? 18'(ldr_pkg::NORM_MAX) : signed'(d.q);
    end else begin
      r = (d.sat || d.q > 18'(-ldr_pkg::NORM_MIN)) ? 18'(ldr_pkg::NORM_MIN)
                                                   : signed'(18'd0 - d.q);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- datapath
  logic [ldr_pkg::COLOR_W-1:0] col [11];
  logic signed [17:0] rx [7];
  logic signed [17:0] ry [7];

  logic signed [35:0] sqx, sqy, pxy;
  logic signed [20:0] d2;
  logic signed [19:0] xx, yy, xy;
  logic signed [41:0] d2sq;
  logic signed [36:0] r2d2;
  logic signed [35:0] k1xy, k2xy;
  logic signed [37:0] k2sx, k1sy;
  logic signed [25:0] d4;
  logic signed [36:0] term1, term1_d;
  logic signed [38:0] tx [4];
  logic signed [38:0] ty [4];
  logic signed [41:0] r4d4;
  logic signed [31:0] fscale;
  logic signed [33:0] phx, phy;
  logic signed [34:0] plx, ply;
  logic signed [34:0] cx, cy;
  logic signed [48:0] mx, my;
  logic signed [49:0] sx, sy;
  logic signed [33:0] dxs, dys;
  ldr_pkg::out_item_t out_reg;

  // truncate toward zero: floor, then step up for negative values with a fraction
  assign dxs = 34'(sx >>> 16) + 34'(sx[49] && (sx[15:0] != '0));
  assign dys = 34'(sy >>> 16) + 34'(sy[49] && (sy[15:0] != '0));
  assign in_frame = !dxs[33] && (dxs < 34'(w_side)) && !dys[33] && (dys < 34'(h_side));

  always_ff @(posedge clk) begin
    if (adv[P0]) begin
      rx[0]  <= clamp_norm(qx);
      ry[0]  <= clamp_norm(qy);
      col[0] <= col_div;
    end
    for (int p = 1; p < 11; p++) begin
      if (adv[P0+p]) begin
        col[p] <= col[p-1];
      end
    end
    for (int p = 1; p < 7; p++) begin
      if (adv[P0+p]) begin
        rx[p] <= rx[p-1];
        ry[p] <= ry[p-1];
      end
    end
    if (adv[P0+1]) begin
      sqx <= rx[0] * rx[0];
      sqy <= ry[0] * ry[0];
      pxy <= rx[0] * ry[0];
    end
    if (adv[P0+2]) begin
      d2 <= 21'((37'(sqx) + 37'(sqy)) >>> ldr_pkg::NORM_FRAC);
      xx <= 20'(sqx >>> ldr_pkg::NORM_FRAC);
      yy <= 20'(sqy >>> ldr_pkg::NORM_FRAC);
      xy <= 20'(pxy >>> ldr_pkg::NORM_FRAC);
    end
    if (adv[P0+3]) begin
      d2sq <= d2 * d2;
      r2d2 <= radial_coef_2 * d2;
      k1xy <= tangential_coef_1 * xy;
      k2xy <= tangential_coef_2 * xy;
      k2sx <= tangential_coef_2 * (22'(d2) + 22'(xx) + 22'(xx));
      k1sy <= tangential_coef_1 * (22'(d2) + 22'(yy) + 22'(yy));
    end
    if (adv[P0+4]) begin
      d4    <= 26'(d2sq >>> ldr_pkg::NORM_FRAC);
      term1 <= r2d2 >>> CF;
      tx[0] <= 39'((k1xy <<< 1) >>> CF) + 39'(k2sx >>> CF);
      ty[0] <= 39'(k1sy >>> CF) + 39'((k2xy <<< 1) >>> CF);
    end
    if (adv[P0+5]) begin
      r4d4    <= radial_coef_4 * d4;
      term1_d <= term1;
    end
    for (int p = 1; p < 4; p++) begin
      if (adv[P0+4+p]) begin
        tx[p] <= tx[p-1];
        ty[p] <= ty[p-1];
      end
    end
    if (adv[P0+6]) begin
      fscale <= 32'(43'sd65536 + 43'(term1_d) + 43'(r4d4 >>> CF));
    end
    if (adv[P0+7]) begin
      // split the scale factor so each product stays narrow
      phx <= rx[6] * $signed(fscale[31:16]);
      plx <= rx[6] * $signed({1'b0, fscale[15:0]});
      phy <= ry[6] * $signed(fscale[31:16]);
      ply <= ry[6] * $signed({1'b0, fscale[15:0]});
    end
    if (adv[P0+8]) begin
      cx <= 35'(40'(phx) + 40'(plx >>> ldr_pkg::NORM_FRAC) + 40'(tx[3]));
      cy <= 35'(40'(phy) + 40'(ply >>> ldr_pkg::NORM_FRAC) + 40'(ty[3]));
    end
    if (adv[P0+9]) begin
      mx <= cx * $signed({1'b0, w_side});
      my <= cy * $signed({1'b0, h_side});
    end
    if (adv[P0+10]) begin
      sx <= 50'(mx) + $signed({22'b0, half_w, 16'b0});
      sy <= 50'(my) + $signed({22'b0, half_h, 16'b0});
    end
    if (adv[LAST]) begin
      out_reg.dest_x    <= dxs[11:0];
      out_reg.dest_y    <= dys[11:0];
      out_reg.out_red   <= col[10][23:16];
      out_reg.out_green <= col[10][15:8];
      out_reg.out_blue  <= col[10][7:0];
    end
  end

  assign result.valid = v[LAST];
  assign result.data  = out_reg;

  // ---------------------------------------------------------------- checks
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (v == '0) |-> pixel.ready)
    else $error("input blocked with empty pipeline");

  a_first_holds: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !adv[1]) |=> v[0])
    else $error("stage 0 lost a pixel under stall");

  a_zero_side: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready && (frame_width == '0)) |=> !v[0])
    else $error("pixel entered with zero frame width");

endmodule
`default_nettype wire

FILE: rtl/core/ldr_norm_div.sv
`default_nettype none
module ldr_norm_div #(
  parameter int SIDE_W = 24
) (
  input  logic                              clk,
  input  logic [ldr_pkg::DIV_STEPS-1:0]     adv,
  input  logic [12:0]                       div_x,
  input  logic [12:0]                       div_y,
  input  ldr_pkg::div_in_t                  in_x,
  input  ldr_pkg::div_in_t                  in_y,
  input  logic [SIDE_W-1:0]                 side_in,
  output ldr_pkg::div_out_t                 out_x,
  output ldr_pkg::div_out_t                 out_y,
  output logic [SIDE_W-1:0]                 side_out
);

  localparam int S  = ldr_pkg::DIV_STEPS;
  localparam int QW = ldr_pkg::Q_W;

  ldr_pkg::div_in_t lane_in [2];
  logic [12:0]      dv      [2];

  logic [12:0]   rem      [2][S];
  logic [QW-1:0] num      [2][S];
  logic [QW-1:0] quo      [2][S];
  logic          neg      [2][S];
  logic          sat      [2][S];
  logic [SIDE_W-1:0] side [S];

  logic [12:0]   rem_prev [2][S];
  logic [QW-1:0] num_prev [2][S];
  logic [QW-1:0] quo_prev [2][S];
  logic [12:0]   rem_next [2][S];
  logic [QW-1:0] num_next [2][S];
  logic [QW-1:0] quo_next [2][S];

  assign lane_in[0] = in_x;
  assign lane_in[1] = in_y;
  assign dv[0]      = div_x;
  assign dv[1]      = div_y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < S; s++) begin : g_step
      logic [13:0] trial;
      logic        ge;

      if (s == 0) begin : g_first
        // numerator is mag << 16; its top bits already sit below the divisor
        assign rem_prev[l][s] = 13'(lane_in[l].mag >> 2);
        assign num_prev[l][s] = {lane_in[l].mag[1:0], {(QW-2){1'b0}}};
        assign quo_prev[l][s] = '0;
      end else begin : g_rest
        assign rem_prev[l][s] = rem[l][s-1];
        assign num_prev[l][s] = num[l][s-1];
        assign quo_prev[l][s] = quo[l][s-1];
      end

      always_comb begin
        trial = {rem_prev[l][s], num_prev[l][s][QW-1]};
        ge    = trial >= {1'b0, dv[l]};
        rem_next[l][s] = ge ? 13'(trial - {1'b0, dv[l]}) : trial[12:0];
        num_next[l][s] = {num_prev[l][s][QW-2:0], 1'b0};
        quo_next[l][s] = {quo_prev[l][s][QW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (adv[s]) begin
          rem[l][s] <= rem_next[l][s];
          num[l][s] <= num_next[l][s];
          quo[l][s] <= quo_next[l][s];
          if (s == 0) begin
            neg[l][s] <= lane_in[l].neg;
            // quotient would need more than QW bits
            sat[l][s] <= {3'b0, lane_in[l].mag} >= {dv[l], 2'b00};
          end else begin
            neg[l][s] <= neg[l][(s == 0) ? 0 : s-1];
            sat[l][s] <= sat[l][(s == 0) ? 0 : s-1];
          end
        end
      end
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        side[s] <= (s == 0) ? side_in : side[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_x.q   = quo[0][S-1];
  assign out_x.neg = neg[0][S-1];
  assign out_x.sat = sat[0][S-1];
  assign out_y.q   = quo[1][S-1];
  assign out_y.neg = neg[1][S-1];
  assign out_y.sat = sat[1][S-1];
  assign side_out  = side[S-1];

endmodule
`default_nettype wire

FILE: tb/ldr_remap_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ldr_remap_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       pixel_valid,
  input  logic       pixel_ready,
  input  ldr_pkg::in_item_t  pixel_data,
  input  logic       result_valid,
  input  logic       result_ready,
  input  ldr_pkg::out_item_t result_data,
  output int         mismatch_count,
  output int         pending_count
);

  localparam longint MAX_SIDE = 4096;
  localparam int COEF_SHIFT = 12;

  logic [12:0]        width_q;
  logic [12:0]        height_q;
  logic signed [15:0] radial2_q;
  logic signed [15:0] radial4_q;
  logic signed [15:0] tang1_q;
  logic signed [15:0] tang2_q;
  ldr_pkg::out_item_t remap_queue[$];

  assign pending_count = remap_queue.size();

  function automatic longint norm_coord(input longint pos, input longint side);
    longint v;
    v = ((pos - side / 2) * 65536) / side;
    if (v > ldr_pkg::NORM_MAX) v = ldr_pkg::NORM_MAX;
    if (v < ldr_pkg::NORM_MIN) v = ldr_pkg::NORM_MIN;
    return v;
  endfunction

  function automatic bit remap_pixel(input ldr_pkg::in_item_t px,
                                     output ldr_pkg::out_item_t res);
    longint w, h, rx, ry, d2, d4, f, xy, xx, yy, cx, cy, dx, dy;
    longint r2, r4, k1, k2;
    r2 = longint'(radial2_q);
    r4 = longint'(radial4_q);
    k1 = longint'(tang1_q);
    k2 = longint'(tang2_q);
    w = (width_q > MAX_SIDE) ? MAX_SIDE : longint'(width_q);
    h = (height_q > MAX_SIDE) ? MAX_SIDE : longint'(height_q);
    res = '0;
    if (w <= 0 || h <= 0) return 1'b0;
    rx = norm_coord(longint'(px.src_x), w);
    ry = norm_coord(longint'(px.src_y), h);
    d2 = (rx * rx + ry * ry) >>> ldr_pkg::NORM_FRAC;
    d4 = (d2 * d2) >>> ldr_pkg::NORM_FRAC;
    f  = 65536 + ((r2 * d2) >>> COEF_SHIFT) + ((r4 * d4) >>> COEF_SHIFT);
    xy = (rx * ry) >>> ldr_pkg::NORM_FRAC;
    xx = (rx * rx) >>> ldr_pkg::NORM_FRAC;
    yy = (ry * ry) >>> ldr_pkg::NORM_FRAC;
    cx = ((rx * f) >>> ldr_pkg::NORM_FRAC) + ((2 * k1 * xy) >>> COEF_SHIFT)
       + ((k2 * (d2 + 2 * xx)) >>> COEF_SHIFT);
    cy = ((ry * f) >>> ldr_pkg::NORM_FRAC) + ((k1 * (d2 + 2 * yy)) >>> COEF_SHIFT)
       + ((2 * k2 * xy) >>> COEF_SHIFT);
    // division truncates toward zero, so (-1, 0) lands on column 0
    dx = (cx * w + (w / 2) * 65536) / 65536;
    dy = (cy * h + (h / 2) * 65536) / 65536;
    if (dx < 0 || dx >= w || dy < 0 || dy >= h) return 1'b0;
    res.dest_x    = dx[11:0];
    res.dest_y    = dy[11:0];
    res.out_red   = px.in_red;
    res.out_green = px.in_green;
    res.out_blue  = px.in_blue;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    ldr_pkg::out_item_t want;
    ldr_pkg::out_item_t got;
    if (rst) begin
      mismatch_count = 0;
      width_q   <= ldr_pkg::WIDTH_RESET;
      height_q  <= ldr_pkg::HEIGHT_RESET;
      radial2_q <= '0;
      radial4_q <= '0;
      tang1_q   <= '0;
      tang2_q   <= '0;
    end else begin
      if (result_valid && result_ready) begin
        got = result_data;
        if (remap_queue.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result %p", $time, got);
          mismatch_count++;
        end else begin
          want = remap_queue.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch expected %p actual %p", $time, want, got);
            mismatch_count++;
          end
        end
      end
      if (pixel_valid && pixel_ready) begin
        if (remap_pixel(pixel_data, want)) remap_queue.push_back(want);
      end
      if (cfg_write) begin
        case (cfg_index)
          ldr_pkg::REG_FRAME_WIDTH:  width_q   <= cfg_data[12:0];
          ldr_pkg::REG_FRAME_HEIGHT: height_q  <= cfg_data[12:0];
          ldr_pkg::REG_RADIAL_2:     radial2_q <= cfg_data;
          ldr_pkg::REG_RADIAL_4:     radial4_q <= cfg_data;
          ldr_pkg::REG_TANGENTIAL_1: tang1_q   <= cfg_data;
          ldr_pkg::REG_TANGENTIAL_2: tang2_q   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_lens_distortion_pixel_remap.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_lens_distortion_pixel_remap;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_PIXELS = 116;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatch_count;
  int          pending_count;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          cur_w;
  int          cur_h;

  ldr_stream_if #(.item_t(ldr_pkg::in_item_t))  pixel ();
  ldr_stream_if #(.item_t(ldr_pkg::out_item_t)) result ();

  lens_distortion_pixel_remap dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel(pixel), .result(result)
  );

  ldr_remap_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel_valid(pixel.valid), .pixel_ready(pixel.ready),
    .pixel_data(pixel.data), .result_valid(result.valid),
    .result_ready(result.ready), .result_data(result.data),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic bit quiet_stretch();
    return sent_count >= 500 && sent_count < 700;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lens_distortion_pixel_remap: FAILED **");
      $finish;
    end
  end

  // receiver: random idling plus one long hold-off so the pipe backs up
  initial begin
    int holdoff;
    bit held;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    holdoff = 0;
    held = 1'b0;
    forever begin
      if (!held && sent_count >= 300) begin
        held = 1'b1;
        holdoff = 300;
      end
      if (holdoff > 0) begin
        result.ready <= 1'b0;
        holdoff--;
      end else if (!quiet_stretch() && $urandom_range(0, 99) < 6) begin
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == ldr_pkg::REG_FRAME_WIDTH)  cur_w = value[12:0];
    if (idx == ldr_pkg::REG_FRAME_HEIGHT) cur_h = value[12:0];
  endtask

  task automatic load_setup(input int w, input int h, input int r2, input int r4,
                            input int k1, input int k2);
    write_reg(ldr_pkg::REG_FRAME_WIDTH, w[15:0]);
    write_reg(ldr_pkg::REG_FRAME_HEIGHT, h[15:0]);
    write_reg(ldr_pkg::REG_RADIAL_2, r2[15:0]);
    write_reg(ldr_pkg::REG_RADIAL_4, r4[15:0]);
    write_reg(ldr_pkg::REG_TANGENTIAL_1, k1[15:0]);
    write_reg(ldr_pkg::REG_TANGENTIAL_2, k2[15:0]);
  endtask

  task automatic send_pixel(input ldr_pkg::in_item_t px);
    while (!quiet_stretch() && $urandom_range(0, 99) < 6) begin
      pixel.valid <= 1'b0;
      @(negedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.data  <= px;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pixel.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic ldr_pkg::in_item_t make_pixel(input int x, input int y);
    ldr_pkg::in_item_t px;
    px.src_x    = x[11:0];
    px.src_y    = y[11:0];
    px.in_red   = 8'($urandom());
    px.in_green = 8'($urandom());
    px.in_blue  = 8'($urandom());
    return px;
  endfunction

  function automatic ldr_pkg::in_item_t random_pixel();
    int wl;
    int hl;
    wl = (cur_w < 1 || cur_w > 4096) ? 4096 : cur_w;
    hl = (cur_h < 1 || cur_h > 4096) ? 4096 : cur_h;
    // mostly in frame; some anywhere in the 12-bit range
    if ($urandom_range(0, 9) < 8)
      return make_pixel($urandom_range(0, wl - 1), $urandom_range(0, hl - 1));
    return make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
  endfunction

  function automatic int random_coef();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return 0;
      default: return $urandom_range(0, 1200) - 600;
    endcase
  endfunction

  initial begin
    ldr_pkg::in_item_t px;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pixel.valid = 1'b0;
    pixel.data  = '0;
    cur_w = 640;
    cur_h = 480;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: corners, center, far outside, color extremes
    px = '0; send_pixel(px);
    px = '1; send_pixel(px);
    send_pixel(make_pixel(639, 479));
    send_pixel(make_pixel(320, 240));
    send_pixel(make_pixel(0, 479));
    send_pixel(make_pixel(639, 0));
    send_pixel(make_pixel(640, 240));
    wait_drained();

    // unit frame, then a negative radial coefficient near the corners
    load_setup(1, 1, 0, 0, 0, 0);
    send_pixel(make_pixel(0, 0));
    send_pixel(make_pixel(4095, 4095));
    wait_drained();
    load_setup(640, 480, -4096, 0, 0, 0);
    send_pixel(make_pixel(1, 1));
    send_pixel(make_pixel(638, 478));
    wait_drained();

    // largest sides, coefficients at the extremes
    load_setup(4096, 4096, 32767, -32768, 32767, -32768);
    send_pixel(make_pixel(0, 4095));
    send_pixel(make_pixel(2048, 2048));
    send_pixel(make_pixel(2049, 2047));
    wait_drained();
    load_setup(4096, 4096, -32768, 32767, -32768, 32767);
    send_pixel(make_pixel(2050, 2046));
    send_pixel(make_pixel(4095, 0));
    wait_drained();

    // sides above the cap, then zero sides (no results), spare indexes ignored
    load_setup(8191, 5000, 0, 0, 0, 0);
    send_pixel(make_pixel(4095, 4095));
    send_pixel(make_pixel(100, 3000));
    wait_drained();
    load_setup(0, 480, 0, 0, 0, 0);
    send_pixel(make_pixel(0, 0));
    wait_drained();
    write_reg(ldr_pkg::REG_FRAME_HEIGHT, 16'd0);
    write_reg(ldr_pkg::REG_FRAME_WIDTH, 16'd320);
    send_pixel(make_pixel(10, 0));
    wait_drained();
    write_reg(REG_SPARE_A, 16'($urandom()));
    write_reg(REG_SPARE_B, 16'($urandom()));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: load_setup($urandom_range(1, 64), $urandom_range(1, 64), random_coef(),
                      random_coef(), random_coef(), random_coef());
        1: load_setup($urandom_range(1, 8191), $urandom_range(1, 8191), random_coef(),
                      random_coef(), random_coef(), random_coef());
        2: load_setup(640, 480, random_coef(), random_coef(), 0, 0);
        default: load_setup($urandom_range(1, 4096), $urandom_range(1, 4096),
                            random_coef(), random_coef(), random_coef(), random_coef());
      endcase
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph == 3 && i == PHASE_PIXELS / 2) begin
          // hold the sender until every result is out
          pixel.valid <= 1'b0;
          while (pending_count != 0) @(negedge clk);
        end
        send_pixel(random_pixel());
      end
      wait_drained();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** lens_distortion_pixel_remap: PASSED **");
    end else begin
      $display("** lens_distortion_pixel_remap: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
